@@ src/uase_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 aware string escaper package
// Shared types, character codes and the escape tables of the token emitter.
// ----------------------------------------------------------------------------
package uase_pkg;

  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_BSL   = 8'h5c;
  localparam logic [7:0] CHAR_U     = 8'h75;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_HEXA  = 8'h57;  // 'a' minus ten
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  // Token kinds the controller hands to the datapath.
  typedef enum logic [2:0] {
    TK_OPEN,
    TK_CLOSE,
    TK_PROC,
    TK_STRAY,
    TK_RAW
  } token_e;

  // How a token expands into output characters.
  typedef enum logic [3:0] {
    CL_NONE,
    CL_HOLD,
    CL_RAW,
    CL_QUOTE,
    CL_CLOSE,
    CL_BSL,
    CL_UHEX,
    CL_OCT,
    CL_ERR
  } class_e;

  typedef struct packed {
    logic       emit;
    token_e     op;
    logic       src_held;
    logic [1:0] idx;
  } tok_cmd_t;

  typedef struct packed {
    logic load_item;
    logic append;
    logic clear_held;
    logic end_string;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic       has;
    logic       eos;
    logic       in_string;
    logic       dropping;
    logic [1:0] held_count;
    logic [1:0] needed;
    logic       cont;
    logic       out_free;
    logic       tok_done;
  } dp_status_t;

  // Number of continuation bytes a lead byte announces, zero if not a lead.
  function automatic logic [1:0] lead_len(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if (b[7:5] == 3'b110) n = 2'd1;
    else if (b[7:4] == 4'b1110) n = 2'd2;
    else if (b[7:3] == 5'b11110) n = 2'd3;
    return n;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = CHAR_ZERO + {4'd0, n};
    else c = CHAR_HEXA + {4'd0, n};
    return c;
  endfunction

  function automatic class_e classify(input token_e op, input logic [7:0] b,
                                      input logic json, input logic dropping);
    class_e cls;
    cls = CL_NONE;
    case (op)
      TK_OPEN:  cls = CL_QUOTE;
      TK_CLOSE: cls = dropping ? CL_NONE : CL_CLOSE;
      TK_RAW:   cls = CL_RAW;
      TK_STRAY: begin
        if (dropping) cls = CL_NONE;
        else cls = json ? CL_ERR : CL_OCT;
      end
      TK_PROC: begin
        if (dropping) cls = CL_NONE;
        else if (b < CTRL_LIMIT) cls = json ? CL_UHEX : CL_OCT;
        else if (b == CHAR_QUOTE || b == CHAR_BSL) cls = CL_BSL;
        else if (lead_len(b) != 2'd0) cls = CL_HOLD;
        else if (b[7]) cls = json ? CL_ERR : CL_OCT;
        else cls = CL_RAW;
      end
      default: cls = CL_NONE;
    endcase
    return cls;
  endfunction

  function automatic logic [2:0] class_len(input class_e cls);
    logic [2:0] n;
    case (cls) inside
      CL_RAW, CL_QUOTE, CL_CLOSE, CL_ERR: n = 3'd1;
      CL_BSL:  n = 3'd2;
      CL_OCT:  n = 3'd4;
      CL_UHEX: n = 3'd6;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] class_char(input class_e cls, input logic [7:0] b,
                                            input logic [2:0] ch);
    logic [7:0] c;
    c = 8'd0;
    case (cls) inside
      CL_RAW:           c = b;
      CL_QUOTE, CL_CLOSE: c = CHAR_QUOTE;
      CL_BSL:           c = (ch == 3'd0) ? CHAR_BSL : b;
      CL_OCT: begin
        case (ch)
          3'd0:    c = CHAR_BSL;
          3'd1:    c = CHAR_ZERO + {6'd0, b[7:6]};
          3'd2:    c = CHAR_ZERO + {5'd0, b[5:3]};
          default: c = CHAR_ZERO + {5'd0, b[2:0]};
        endcase
      end
      CL_UHEX: begin
        case (ch)
          3'd0:    c = CHAR_BSL;
          3'd1:    c = CHAR_U;
          3'd2:    c = CHAR_ZERO;
          3'd3:    c = CHAR_ZERO;
          3'd4:    c = hex_char(b[7:4]);
          default: c = hex_char(b[3:0]);
        endcase
      end
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

@@ src/uase_dp.sv @@
// ----------------------------------------------------------------------------
// Escaper datapath
// Item and held-byte registers, string state, token emitter with its
// character counter, a one-deep pending result and the output register.
// ----------------------------------------------------------------------------
module uase_dp import uase_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  logic       has_byte_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_string_i,
  input  tok_cmd_t   tok_i,
  input  ctl_cmd_t   ctl_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_done_o,
  output logic       json_error_o
);

  logic       json_q;
  logic       in_string_q;
  logic       dropping_q;
  logic [1:0] held_count_q;
  logic [1:0] needed_q;
  logic [2:0] ch_q;
  logic       pend_valid_q;
  logic       out_valid_q;

  logic       item_has_q;
  logic [7:0] item_byte_q;
  logic       item_end_q;
  logic [7:0] held_q [3];
  logic [7:0] pend_byte_q;
  logic       pend_done_q;
  logic       pend_err_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       out_done_q;
  logic       out_err_q;

  logic [7:0] held_sel;
  logic [7:0] cur_byte;
  class_e     cls;
  logic [2:0] len;
  logic       last_ch;
  logic       tok_done;
  logic       produce;
  logic       move_out;
  logic       out_free;

  always_comb begin
    case (tok_i.idx)
      2'd0:    held_sel = held_q[0];
      2'd1:    held_sel = held_q[1];
      default: held_sel = held_q[2];
    endcase
  end

  assign cur_byte = tok_i.src_held ? held_sel : item_byte_q;
  assign cls      = classify(tok_i.op, cur_byte, json_q, dropping_q);
  assign len      = class_len(cls);
  assign last_ch  = (ch_q == len - 3'd1);
  assign tok_done = tok_i.emit && (len == 3'd0 || last_ch);
  assign produce  = tok_i.emit && (len != 3'd0);
  // The pending result leaves when a newer one arrives or the item finishes.
  assign move_out = pend_valid_q && (produce || ctl_i.finish);
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      json_q       <= 1'b0;
      in_string_q  <= 1'b0;
      dropping_q   <= 1'b0;
      held_count_q <= 2'd0;
      needed_q     <= 2'd0;
      ch_q         <= 3'd0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        json_q <= cfg_data_i;
      end
      if (produce) begin
        ch_q <= last_ch ? 3'd0 : ch_q + 3'd1;
      end
      if (tok_done && tok_i.op == TK_OPEN) begin
        in_string_q <= 1'b1;
      end
      if (tok_done && cls == CL_ERR) begin
        dropping_q <= 1'b1;
      end
      if (tok_done && cls == CL_HOLD) begin
        held_count_q <= 2'd1;
        needed_q     <= lead_len(cur_byte);
      end
      if (ctl_i.append) begin
        if (held_count_q != 2'd3) begin
          held_count_q <= held_count_q + 2'd1;
        end
        needed_q <= needed_q - 2'd1;
      end
      if (ctl_i.clear_held) begin
        held_count_q <= 2'd0;
        needed_q     <= 2'd0;
      end
      if (ctl_i.end_string || (tok_done && tok_i.op == TK_CLOSE)) begin
        in_string_q  <= 1'b0;
        dropping_q   <= 1'b0;
        held_count_q <= 2'd0;
        needed_q     <= 2'd0;
      end
      if (produce) begin
        pend_valid_q <= 1'b1;
      end else if (ctl_i.finish) begin
        pend_valid_q <= 1'b0;
      end
      if (move_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_item) begin
      item_has_q  <= has_byte_i;
      item_byte_q <= data_byte_i;
      item_end_q  <= end_of_string_i;
    end
    if (tok_done && cls == CL_HOLD) begin
      held_q[0] <= cur_byte;
    end
    if (ctl_i.append) begin
      if (held_count_q == 2'd1) begin
        held_q[1] <= item_byte_q;
      end
      if (held_count_q == 2'd2) begin
        held_q[2] <= item_byte_q;
      end
    end
    if (produce) begin
      pend_byte_q <= class_char(cls, cur_byte, ch_q);
      pend_done_q <= (cls == CL_CLOSE) || (cls == CL_ERR);
      pend_err_q  <= (cls == CL_ERR);
    end
    if (move_out) begin
      out_byte_q <= pend_byte_q;
      out_done_q <= pend_done_q;
      out_err_q  <= pend_err_q;
      out_last_q <= ctl_i.finish;
    end
  end

  assign status_o.has        = item_has_q;
  assign status_o.eos        = item_end_q;
  assign status_o.in_string  = in_string_q;
  assign status_o.dropping   = dropping_q;
  assign status_o.held_count = held_count_q;
  assign status_o.needed     = needed_q;
  assign status_o.cont       = (item_byte_q[7:6] == 2'b10);
  assign status_o.out_free   = out_free;
  assign status_o.tok_done   = tok_done;

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign run_last_o    = out_last_q;
  assign string_done_o = out_done_q;
  assign json_error_o  = out_err_q;

endmodule

@@ src/uase_ctrl.sv @@
// ----------------------------------------------------------------------------
// Escaper controller
// Walks one item through opening quote, byte handling, held-byte flush and
// closing quote, issuing one token at a time to the datapath.
// ----------------------------------------------------------------------------
module uase_ctrl import uase_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output tok_cmd_t   tok_o,
  output ctl_cmd_t   ctl_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_OPEN  = 4'd1;
  localparam logic [3:0] S_TAKE  = 4'd2;
  localparam logic [3:0] S_PASS  = 4'd3;
  localparam logic [3:0] S_FLUSH = 4'd4;
  localparam logic [3:0] S_PROCB = 4'd5;
  localparam logic [3:0] S_END   = 4'd6;
  localparam logic [3:0] S_CLOSE = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic       ret_close_q, ret_close_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    ret_close_d = ret_close_q;
    tok_o       = '{emit: 1'b0, op: TK_RAW, src_held: 1'b0, idx: idx_q};
    ctl_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        ctl_o.load_item = in_valid_i;
        // A bubble item is taken and leaves no trace.
        if (in_valid_i) begin
          state_d = S_OPEN;
        end
      end
      S_OPEN: begin
        if (status_i.out_free) begin
          if (status_i.in_string) begin
            state_d = S_TAKE;
          end else begin
            tok_o.emit = 1'b1;
            tok_o.op   = TK_OPEN;
            if (status_i.tok_done) state_d = S_TAKE;
          end
        end
      end
      S_TAKE: begin
        if (status_i.out_free) begin
          idx_d = 2'd0;
          if (!status_i.has || status_i.dropping) begin
            state_d = S_END;
          end else if (status_i.held_count == 2'd0) begin
            state_d = S_PROCB;
          end else if (status_i.cont && status_i.needed != 2'd0) begin
            if (status_i.needed == 2'd1) begin
              state_d = S_PASS;
            end else begin
              ctl_o.append = 1'b1;
              state_d      = S_END;
            end
          end else begin
            ret_close_d = 1'b0;
            state_d     = S_FLUSH;
          end
        end
      end
      S_PASS: begin
        // Complete sequence: held bytes, then the current byte, all verbatim.
        if (status_i.out_free) begin
          tok_o.emit     = 1'b1;
          tok_o.op       = TK_RAW;
          tok_o.src_held = (idx_q != status_i.held_count);
          if (status_i.tok_done) begin
            if (idx_q == status_i.held_count) begin
              ctl_o.clear_held = 1'b1;
              state_d          = S_END;
            end else begin
              idx_d = idx_q + 2'd1;
            end
          end
        end
      end
      S_FLUSH: begin
        if (status_i.out_free) begin
          tok_o.emit     = 1'b1;
          tok_o.op       = TK_STRAY;
          tok_o.src_held = 1'b1;
          if (status_i.tok_done) begin
            if (idx_q == status_i.held_count - 2'd1) begin
              ctl_o.clear_held = 1'b1;
              state_d          = ret_close_q ? S_CLOSE : S_PROCB;
            end else begin
              idx_d = idx_q + 2'd1;
            end
          end
        end
      end
      S_PROCB: begin
        if (status_i.out_free) begin
          tok_o.emit = 1'b1;
          tok_o.op   = TK_PROC;
          if (status_i.tok_done) state_d = S_END;
        end
      end
      S_END: begin
        if (status_i.out_free) begin
          idx_d = 2'd0;
          if (!status_i.eos) begin
            state_d = S_FIN;
          end else if (status_i.dropping) begin
            ctl_o.end_string = 1'b1;
            state_d          = S_FIN;
          end else if (status_i.held_count != 2'd0) begin
            ret_close_d = 1'b1;
            state_d     = S_FLUSH;
          end else begin
            state_d = S_CLOSE;
          end
        end
      end
      S_CLOSE: begin
        if (status_i.out_free) begin
          tok_o.emit = 1'b1;
          tok_o.op   = TK_CLOSE;
          if (status_i.tok_done) state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (status_i.out_free) begin
          ctl_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= 2'd0;
      ret_close_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      ret_close_q <= ret_close_d;
    end
  end

endmodule

@@ src/utf8_aware_string_escaper_unit.sv @@
// ----------------------------------------------------------------------------
// UTF-8 aware string escaper
// Turns a byte stream into its quoted, escaped form, passing well-formed
// UTF-8 sequences through unchanged.
//
//   Channel   Direction  Handshake          Payload
//   input     in         in_valid/in_stall  has_byte, data_byte, end_of_string
//   output    out        out_valid/out_stall out_byte, run_last, string_done,
//                                           json_error
//   config    in         cfg_valid/cfg_ready cfg_data (json_mode)
//
// One item is handled at a time: it is accepted, then the controller steps
// through its states, and the token emitter produces one character per cycle
// while the output register is free.
// Reset clears the string state and the mode; held bytes need no clearing.
// A stalled output freezes the controller outside idle whenever the output register is full.
// ----------------------------------------------------------------------------
module utf8_aware_string_escaper_unit import uase_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       has_byte_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_done_o,
  output logic       json_error_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);

  tok_cmd_t   tok;
  ctl_cmd_t   ctl;
  dp_status_t status;
  logic       in_valid_item;

  assign cfg_ready_o = 1'b1;
  // A bubble item is accepted but never starts the sequencer.
  assign in_valid_item = in_valid_i && (has_byte_i || end_of_string_i);

  uase_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_item),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .tok_o      (tok),
    .ctl_o      (ctl)
  );

  uase_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .has_byte_i      (has_byte_i),
    .data_byte_i     (data_byte_i),
    .end_of_string_i (end_of_string_i),
    .tok_i           (tok),
    .ctl_i           (ctl),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .run_last_o      (run_last_o),
    .string_done_o   (string_done_o),
    .json_error_o    (json_error_o)
  );

endmodule
